// File: design/expedite_priority_queue_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the expedite priority queue
// Shorthand for clocked, reset-qualified concurrent checks.
// ----------------------------------------------------------------------------
`ifndef EXPEDITE_PRIORITY_QUEUE_MACROS_SVH
`define EXPEDITE_PRIORITY_QUEUE_MACROS_SVH

// Same-cycle implication
`define EPQ_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("queue check failed");

// Next-cycle implication
`define EPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("queue check failed");

`endif

// File: design/epq_pkg.sv
// ----------------------------------------------------------------------------
// epq_pkg
// Shared sizes, codes and controller/datapath link types of the queue.
// ----------------------------------------------------------------------------
package epq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int FLIGHT_W    = 14;
    localparam int ORIGIN_W    = 16;
    localparam int OP_W        = 2;
    localparam int STATUS_W    = 3;
    localparam int TDATA_W     = 32;

    typedef logic [FLIGHT_W-1:0] flight_t;
    typedef logic [ORIGIN_W-1:0] origin_t;
    typedef logic [IDX_W-1:0]    idx_t;
    typedef logic [CNT_W-1:0]    cnt_t;

    // request codes
    typedef enum logic [OP_W-1:0] {
        OP_ENQUEUE  = 2'd0,
        OP_DEQUEUE  = 2'd1,
        OP_EXPEDITE = 2'd2,
        OP_DUMP     = 2'd3
    } op_t;

    // result codes
    typedef enum logic [STATUS_W-1:0] {
        ST_QUEUED    = 3'd0,
        ST_ENTRY     = 3'd1,
        ST_EMPTY     = 3'd2,
        ST_FULL      = 3'd3,
        ST_NOTFOUND  = 3'd4,
        ST_EXPEDITED = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        CTL_IDLE,
        CTL_FIND,
        CTL_EXEC,
        CTL_DUMP
    } ctl_state_t;

    // controller -> datapath
    typedef struct packed {
        logic load;   // latch the accepted request word
        logic find;   // register the flight search result
        logic fire;   // carry out one step and write one result word
    } epq_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic slot_free;  // result register can take a word this cycle
        logic dump_more;  // a dump has words left after the current one
    } epq_sts_t;

endpackage

// File: design/epq_ctrl.sv
// ----------------------------------------------------------------------------
// epq_ctrl
// Sequencer: accept a request, search for expedite, execute, walk a dump.
// ----------------------------------------------------------------------------
module epq_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  epq_pkg::op_t      in_op,
    output logic              in_ready,
    input  epq_pkg::epq_sts_t sts,
    output epq_pkg::epq_cmd_t cmd
);

    epq_pkg::ctl_state_t state_reg;
    epq_pkg::ctl_state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= epq_pkg::CTL_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            epq_pkg::CTL_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = (in_op == epq_pkg::OP_EXPEDITE) ? epq_pkg::CTL_FIND
                                                                 : epq_pkg::CTL_EXEC;
                end
            end
            epq_pkg::CTL_FIND:
            begin
                state_next = epq_pkg::CTL_EXEC;
            end
            epq_pkg::CTL_EXEC:
            begin
                if (sts.slot_free)
                begin
                    state_next = sts.dump_more ? epq_pkg::CTL_DUMP : epq_pkg::CTL_IDLE;
                end
            end
            epq_pkg::CTL_DUMP:
            begin
                if (sts.slot_free && !sts.dump_more)
                begin
                    state_next = epq_pkg::CTL_IDLE;
                end
            end
            default:
            begin
                state_next = epq_pkg::CTL_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        in_ready = 1'b0;
        cmd      = '0;
        unique case (state_reg)
            epq_pkg::CTL_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            epq_pkg::CTL_FIND:
            begin
                cmd.find = 1'b1;
            end
            epq_pkg::CTL_EXEC,
            epq_pkg::CTL_DUMP:
            begin
                cmd.fire = sts.slot_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

// File: design/epq_datapath.sv
// ----------------------------------------------------------------------------
// epq_datapath
// Entry store, parallel flight search, shift network and result register.
// ----------------------------------------------------------------------------
module epq_datapath (
    input  logic                           clk,
    input  logic                           rst_n,
    input  epq_pkg::epq_cmd_t              cmd,
    output epq_pkg::epq_sts_t              sts,
    input  epq_pkg::op_t                   in_op,
    input  epq_pkg::flight_t               in_flight,
    input  epq_pkg::origin_t               in_origin,
    input  logic                           out_ready,
    output logic                           out_valid,
    output logic [epq_pkg::STATUS_W-1:0]   out_status,
    output epq_pkg::flight_t               out_flight,
    output epq_pkg::origin_t               out_origin,
    output logic                           out_last
);

    localparam int DEPTH = epq_pkg::QUEUE_DEPTH;
    localparam int CW    = epq_pkg::CNT_W;
    localparam int IW    = epq_pkg::IDX_W;

    // request word
    epq_pkg::op_t     op_reg;
    epq_pkg::flight_t flight_in_reg;
    epq_pkg::origin_t origin_in_reg;

    // entry store, head at index 0
    epq_pkg::flight_t entry_flight_reg  [DEPTH];
    epq_pkg::origin_t entry_origin_reg  [DEPTH];
    epq_pkg::flight_t entry_flight_next [DEPTH];
    epq_pkg::origin_t entry_origin_next [DEPTH];

    epq_pkg::cnt_t occ_reg, occ_next;
    epq_pkg::cnt_t urgent_reg, urgent_next;
    epq_pkg::cnt_t dump_cnt_reg, dump_cnt_next;

    // search result
    epq_pkg::idx_t pos_reg, pos_comb;
    logic          found_reg, found_comb;

    // result register
    logic                  out_valid_reg;
    epq_pkg::status_t      out_status_reg;
    epq_pkg::flight_t      out_flight_reg;
    epq_pkg::origin_t      out_origin_reg;
    logic                  out_last_reg;

    epq_pkg::status_t res_status;
    epq_pkg::flight_t res_flight;
    epq_pkg::origin_t res_origin;
    logic             res_last;

    logic is_empty, is_full, dump_last;

    assign is_empty  = (occ_reg == '0);
    assign is_full   = (occ_reg == CW'(DEPTH));
    assign dump_last = (dump_cnt_reg == (occ_reg - CW'(1)));

    assign sts.slot_free = !out_valid_reg || out_ready;
    assign sts.dump_more = (op_reg == epq_pkg::OP_DUMP) && !is_empty && !dump_last;

    // request capture
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg        <= in_op;
            flight_in_reg <= in_flight;
            origin_in_reg <= in_origin;
        end
    end

    // parallel compare, lowest matching index wins
    always_comb
    begin
        found_comb = 1'b0;
        pos_comb   = '0;
        for (int i = DEPTH - 1; i >= 0; i--)
        begin
            if ((CW'(i) < occ_reg) && (entry_flight_reg[i] == flight_in_reg))
            begin
                found_comb = 1'b1;
                pos_comb   = IW'(i);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.find)
        begin
            pos_reg   <= pos_comb;
            found_reg <= found_comb;
        end
    end

    // step logic: store update and result word
    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            entry_flight_next[i] = entry_flight_reg[i];
            entry_origin_next[i] = entry_origin_reg[i];
        end
        occ_next      = occ_reg;
        urgent_next   = urgent_reg;
        dump_cnt_next = dump_cnt_reg;
        res_status    = epq_pkg::ST_QUEUED;
        res_flight    = '0;
        res_origin    = '0;
        res_last      = 1'b1;

        case (op_reg)
            epq_pkg::OP_ENQUEUE:
            begin
                if (is_full)
                begin
                    res_status = epq_pkg::ST_FULL;
                end
                else
                begin
                    entry_flight_next[occ_reg[IW-1:0]] = flight_in_reg;
                    entry_origin_next[occ_reg[IW-1:0]] = origin_in_reg;
                    occ_next   = occ_reg + CW'(1);
                    res_status = epq_pkg::ST_QUEUED;
                end
            end
            epq_pkg::OP_DEQUEUE:
            begin
                if (is_empty)
                begin
                    res_status = epq_pkg::ST_EMPTY;
                end
                else
                begin
                    res_status = epq_pkg::ST_ENTRY;
                    res_flight = entry_flight_reg[0];
                    res_origin = entry_origin_reg[0];
                    for (int i = 0; i < DEPTH - 1; i++)
                    begin
                        entry_flight_next[i] = entry_flight_reg[i + 1];
                        entry_origin_next[i] = entry_origin_reg[i + 1];
                    end
                    occ_next = occ_reg - CW'(1);
                    if (urgent_reg != '0)
                    begin
                        urgent_next = urgent_reg - CW'(1);
                    end
                end
            end
            epq_pkg::OP_EXPEDITE:
            begin
                if (!found_reg)
                begin
                    res_status = epq_pkg::ST_NOTFOUND;
                end
                else
                begin
                    res_status = epq_pkg::ST_EXPEDITED;
                    if (CW'(pos_reg) >= urgent_reg)
                    begin
                        // open a gap behind the urgent group
                        for (int i = 1; i < DEPTH; i++)
                        begin
                            if ((CW'(i) > urgent_reg) && (CW'(i) <= CW'(pos_reg)))
                            begin
                                entry_flight_next[i] = entry_flight_reg[i - 1];
                                entry_origin_next[i] = entry_origin_reg[i - 1];
                            end
                        end
                        // drop the matched entry into it
                        for (int i = 0; i < DEPTH; i++)
                        begin
                            if (CW'(i) == urgent_reg)
                            begin
                                entry_flight_next[i] = flight_in_reg;
                                entry_origin_next[i] = entry_origin_reg[pos_reg];
                            end
                        end
                        urgent_next = urgent_reg + CW'(1);
                    end
                end
            end
            epq_pkg::OP_DUMP:
            begin
                if (is_empty)
                begin
                    res_status = epq_pkg::ST_EMPTY;
                end
                else
                begin
                    // emit the head and rotate it to the tail
                    res_status = epq_pkg::ST_ENTRY;
                    res_flight = entry_flight_reg[0];
                    res_origin = entry_origin_reg[0];
                    res_last   = dump_last;
                    for (int i = 0; i < DEPTH - 1; i++)
                    begin
                        entry_flight_next[i] = entry_flight_reg[i + 1];
                        entry_origin_next[i] = entry_origin_reg[i + 1];
                    end
                    entry_flight_next[IW'(occ_reg - CW'(1))] = entry_flight_reg[0];
                    entry_origin_next[IW'(occ_reg - CW'(1))] = entry_origin_reg[0];
                    dump_cnt_next = dump_last ? '0 : (dump_cnt_reg + CW'(1));
                end
            end
            default:
            begin
                res_status = epq_pkg::ST_QUEUED;
            end
        endcase
    end

    // entry store
    always_ff @(posedge clk)
    begin
        if (cmd.fire)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                entry_flight_reg[i] <= entry_flight_next[i];
                entry_origin_reg[i] <= entry_origin_next[i];
            end
        end
    end

    // counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg      <= '0;
            urgent_reg   <= '0;
            dump_cnt_reg <= '0;
        end
        else if (cmd.load)
        begin
            dump_cnt_reg <= '0;
        end
        else if (cmd.fire)
        begin
            occ_reg      <= occ_next;
            urgent_reg   <= urgent_next;
            dump_cnt_reg <= dump_cnt_next;
        end
    end

    // result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (cmd.fire)
        begin
            out_status_reg <= res_status;
            out_flight_reg <= res_flight;
            out_origin_reg <= res_origin;
            out_last_reg   <= res_last;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_flight = out_flight_reg;
    assign out_origin = out_origin_reg;
    assign out_last   = out_last_reg;

endmodule

// File: design/expedite_priority_queue.sv
// A request word is latched into the request register; its result word is written to the result register
// when the step fires (for an expedite the flight search result is registered before the entries move).
// Throughput: one request at a time; a dump gives one word per cycle while the receiver
// takes them, and holds the block until its last word is written.
// Reset (rst_n low, asynchronous): queue empty, urgent group empty, no result
// pending; stored entries are not cleared.
// ----------------------------------------------------------------------------
// expedite_priority_queue
// Bounded flight queue with an urgent group at the front, stream interfaces.
// ----------------------------------------------------------------------------
`include "expedite_priority_queue_macros.svh"

module expedite_priority_queue (
    input  logic                          clk,
    input  logic                          rst_n,
    // request channel
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [epq_pkg::TDATA_W-1:0]   s_axis_tdata,   // [13:0] flight_number,
                                                          // [29:14] origin_code, [31:30] 0
    input  logic [epq_pkg::OP_W-1:0]      s_axis_tuser,   // [1:0] op
    // result channel
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [epq_pkg::TDATA_W-1:0]   m_axis_tdata,   // [13:0] out_flight,
                                                          // [29:14] out_origin, [31:30] 0
    output logic [epq_pkg::STATUS_W-1:0]  m_axis_tuser,   // [2:0] status
    output logic                          m_axis_tlast
);

    localparam int FW = epq_pkg::FLIGHT_W;
    localparam int OW = epq_pkg::ORIGIN_W;

    epq_pkg::epq_cmd_t cmd;
    epq_pkg::epq_sts_t sts;
    epq_pkg::flight_t  res_flight;
    epq_pkg::origin_t  res_origin;

    // sequencer
    epq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_op    (epq_pkg::op_t'(s_axis_tuser)),
        .in_ready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // store and result path
    epq_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .in_op      (epq_pkg::op_t'(s_axis_tuser)),
        .in_flight  (s_axis_tdata[FW-1:0]),
        .in_origin  (s_axis_tdata[FW+OW-1:FW]),
        .out_ready  (m_axis_tready),
        .out_valid  (m_axis_tvalid),
        .out_status (m_axis_tuser),
        .out_flight (res_flight),
        .out_origin (res_origin),
        .out_last   (m_axis_tlast)
    );

    // pack result word
    assign m_axis_tdata = {{(epq_pkg::TDATA_W - FW - OW){1'b0}}, res_origin, res_flight};

    // checks
    `EPQ_ASSERT_IMPL(a_cmd_exclusive, clk, rst_n, 1'b1, $onehot0(cmd))
    `EPQ_ASSERT_IMPL(a_fire_needs_slot, clk, rst_n, cmd.fire, sts.slot_free)
    `EPQ_ASSERT_NEXT(a_one_request, clk, rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)
    `EPQ_ASSERT_NEXT(a_fire_shows_word, clk, rst_n, cmd.fire, m_axis_tvalid)

endmodule

// File: bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the expedite priority queue. A directed table
// covers the empty, full, duplicate and urgent-group cases. Random requests
// follow, biased to swing between filling and draining the queue. Every
// result word is compared with a software copy of the queue, under four
// patterns of sender idling and receiver stalls.
// ----------------------------------------------------------------------------
module testbench;
    import epq_pkg::*;

    localparam int WATCHDOG_LIMIT   = 2000;
    localparam int DRAIN_CYCLES     = 24;
    localparam int RANDOM_PER_PHASE = 95;
    localparam int NUM_DIRECTED     = 18;

    typedef struct {
        status_t status;
        flight_t flight;
        origin_t origin;
        logic    last;
    } result_word_t;

    // one row of the directed table; reps > 1 steps flight and origin by one
    typedef struct {
        op_t     op;
        flight_t flight;
        origin_t origin;
        int      reps;
        bit      typed;
        status_t typed_status;
    } stim_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [TDATA_W-1:0]    s_axis_tdata;
    logic [OP_W-1:0]       s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [TDATA_W-1:0]    m_axis_tdata;
    logic [STATUS_W-1:0]   m_axis_tuser;
    logic                  m_axis_tlast;

    // software copy of the queue, head at index 0
    flight_t held_flight [QUEUE_DEPTH];
    origin_t held_origin [QUEUE_DEPTH];
    int      held_count  = 0;
    int      urgent_len  = 0;

    result_word_t pending_results [$];

    int mismatches    = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int quiet_cycles  = 0;
    int ops_sent [4]  = '{0, 0, 0, 0};
    int status_seen [6] = '{0, 0, 0, 0, 0, 0};
    int words_checked = 0;

    stim_row_t directed_rows [NUM_DIRECTED] = '{
        '{OP_DUMP,     14'd0,    16'h0000, 1,  1'b1, ST_EMPTY},
        '{OP_DEQUEUE,  14'd0,    16'h0000, 1,  1'b1, ST_EMPTY},
        '{OP_EXPEDITE, 14'd9999, 16'h0000, 1,  1'b1, ST_NOTFOUND},
        '{OP_ENQUEUE,  14'd0,    16'h0000, 1,  1'b1, ST_QUEUED},
        '{OP_ENQUEUE,  14'd9999, 16'hFFFF, 1,  1'b1, ST_QUEUED},
        '{OP_ENQUEUE,  14'd1234, 16'hA5A5, 1,  1'b1, ST_QUEUED},
        '{OP_ENQUEUE,  14'd1234, 16'h5A5A, 1,  1'b1, ST_QUEUED},
        // duplicate flight: the one nearest the head moves to the front
        '{OP_EXPEDITE, 14'd1234, 16'h0000, 1,  1'b1, ST_EXPEDITED},
        // already urgent: stays put
        '{OP_EXPEDITE, 14'd1234, 16'h0000, 1,  1'b1, ST_EXPEDITED},
        '{OP_DUMP,     14'd0,    16'h0000, 1,  1'b0, ST_QUEUED},
        // pop from the urgent group empties it
        '{OP_DEQUEUE,  14'd0,    16'h0000, 1,  1'b0, ST_QUEUED},
        // head expedited with no urgent group
        '{OP_EXPEDITE, 14'd0,    16'h0000, 1,  1'b1, ST_EXPEDITED},
        '{OP_ENQUEUE,  14'd100,  16'h0100, 13, 1'b0, ST_QUEUED},
        '{OP_ENQUEUE,  14'd5555, 16'hFFFF, 1,  1'b1, ST_FULL},
        '{OP_DUMP,     14'd0,    16'h0000, 1,  1'b0, ST_QUEUED},
        // tail entry jumps to just behind the urgent group
        '{OP_EXPEDITE, 14'd112,  16'h0000, 1,  1'b0, ST_QUEUED},
        '{OP_DEQUEUE,  14'd0,    16'h0000, 3,  1'b0, ST_QUEUED},
        '{OP_DUMP,     14'd0,    16'h0000, 1,  1'b0, ST_QUEUED}
    };

    expedite_priority_queue DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void push_result(status_t st, flight_t f, origin_t o, logic is_last);
        result_word_t w;
        w.status = st;
        w.flight = f;
        w.origin = o;
        w.last   = is_last;
        pending_results.push_back(w);
    endfunction

    // apply one request to the software queue and queue up its result words
    function automatic void advance_queue(op_t op, flight_t f, origin_t o);
        int      pos;
        flight_t mf;
        origin_t mo;
        pos = held_count;
        case (op)
            OP_ENQUEUE:
            begin
                if (held_count >= QUEUE_DEPTH)
                    push_result(ST_FULL, '0, '0, 1'b1);
                else
                begin
                    held_flight[held_count] = f;
                    held_origin[held_count] = o;
                    held_count++;
                    push_result(ST_QUEUED, '0, '0, 1'b1);
                end
            end
            OP_DEQUEUE:
            begin
                if (held_count == 0)
                    push_result(ST_EMPTY, '0, '0, 1'b1);
                else
                begin
                    push_result(ST_ENTRY, held_flight[0], held_origin[0], 1'b1);
                    for (int i = 1; i < held_count; i++)
                    begin
                        held_flight[i-1] = held_flight[i];
                        held_origin[i-1] = held_origin[i];
                    end
                    held_count--;
                    if (urgent_len > 0)
                        urgent_len--;
                end
            end
            OP_EXPEDITE:
            begin
                for (int i = 0; i < held_count; i++)
                begin
                    if (held_flight[i] == f && pos == held_count)
                        pos = i;
                end
                if (pos >= held_count)
                    push_result(ST_NOTFOUND, '0, '0, 1'b1);
                else
                begin
                    // urgent entries keep their place
                    if (pos >= urgent_len)
                    begin
                        mf = held_flight[pos];
                        mo = held_origin[pos];
                        for (int i = pos; i > urgent_len; i--)
                        begin
                            held_flight[i] = held_flight[i-1];
                            held_origin[i] = held_origin[i-1];
                        end
                        held_flight[urgent_len] = mf;
                        held_origin[urgent_len] = mo;
                        urgent_len++;
                    end
                    push_result(ST_EXPEDITED, '0, '0, 1'b1);
                end
            end
            OP_DUMP:
            begin
                if (held_count == 0)
                    push_result(ST_EMPTY, '0, '0, 1'b1);
                else
                    for (int i = 0; i < held_count; i++)
                        push_result(ST_ENTRY, held_flight[i], held_origin[i],
                                    i == held_count - 1);
            end
        endcase
    endfunction

    // flight for a random request; expedites mostly name a queued flight
    function automatic flight_t pick_flight(bit from_queue);
        int r;
        r = $urandom_range(99);
        if (from_queue && held_count > 0 && r < 60)
            return held_flight[$urandom_range(held_count - 1)];
        if (r < 75)
            return flight_t'($urandom_range(7));
        if (r < 80)
            return (r % 2) ? flight_t'(9999) : flight_t'(0);
        return flight_t'($urandom_range(9999));
    endfunction

    // drive one request word; called and returns at a falling edge
    task automatic send_word(op_t op, flight_t f, origin_t o, bit typed, status_t typed_st);
        result_word_t w;
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid = 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {2'b00, o, f};
        s_axis_tuser  = op;
        do
            @(posedge clk);
        while (!s_axis_tready);
        advance_queue(op, f, o);
        // hand-written expectation replaces the computed one
        if (typed)
        begin
            void'(pending_results.pop_back());
            w.status = typed_st;
            w.flight = '0;
            w.origin = '0;
            w.last   = 1'b1;
            pending_results.push_back(w);
        end
        ops_sent[int'(op)]++;
        @(negedge clk);
    endtask

    // receiver backpressure
    always @(negedge clk)
    begin
        m_axis_tready = ($urandom_range(99) >= recv_stall_pct);
    end

    // result checker
    always @(posedge clk)
    begin
        result_word_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            words_checked++;
            if (m_axis_tuser < 6)
                status_seen[m_axis_tuser]++;
            if (pending_results.size() == 0)
            begin
                $error("unexpected result word: status %0d, flight %0d",
                       m_axis_tuser, m_axis_tdata[13:0]);
                mismatches++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (m_axis_tuser !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, m_axis_tuser);
                    mismatches++;
                end
                if (m_axis_tdata[13:0] !== want.flight)
                begin
                    $error("out_flight: expected %0d, got %0d",
                           want.flight, m_axis_tdata[13:0]);
                    mismatches++;
                end
                if (m_axis_tdata[29:14] !== want.origin)
                begin
                    $error("out_origin: expected %0d, got %0d",
                           want.origin, m_axis_tdata[29:14]);
                    mismatches++;
                end
                if (m_axis_tlast !== want.last)
                begin
                    $error("last: expected %0d, got %0d", want.last, m_axis_tlast);
                    mismatches++;
                end
            end
        end
    end

    // watchdog on handshake activity
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no word moved for %0d cycles, %0d results outstanding",
                         WATCHDOG_LIMIT, pending_results.size());
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // stimulus
    initial
    begin
        int      roll;
        int      trend_left;
        bit      filling;
        op_t     op;
        flight_t f;
        origin_t o;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = OP_ENQUEUE;
        m_axis_tready = 1'b0;
        filling       = 1'b1;
        trend_left    = 20;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed table
        foreach (directed_rows[r])
            for (int k = 0; k < directed_rows[r].reps; k++)
                send_word(directed_rows[r].op,
                          flight_t'(directed_rows[r].flight + k),
                          origin_t'(directed_rows[r].origin + k),
                          directed_rows[r].typed, directed_rows[r].typed_status);

        // random phases: free flow, sender gaps, receiver stalls, light both
        for (int p = 0; p < 4; p++)
        begin
            send_idle_pct  = (p == 1) ? 73 : (p == 3) ? 9 : 0;
            recv_stall_pct = (p == 2) ? 73 : (p == 3) ? 9 : 0;
            for (int n = 0; n < RANDOM_PER_PHASE; n++)
            begin
                // swing between filling and draining so both ends get hit
                trend_left--;
                if (trend_left == 0)
                begin
                    filling    = !filling;
                    trend_left = $urandom_range(30, 8);
                end
                roll = $urandom_range(99);
                if (roll < (filling ? 55 : 20))
                    op = OP_ENQUEUE;
                else if (roll < 70)
                    op = OP_DEQUEUE;
                else if (roll < 90)
                    op = OP_EXPEDITE;
                else
                    op = OP_DUMP;
                f = pick_flight(op == OP_EXPEDITE);
                o = origin_t'($urandom_range(65535));
                send_word(op, f, o, 1'b0, ST_QUEUED);
            end
        end
        s_axis_tvalid = 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d enqueue, %0d dequeue, %0d expedite and %0d dump requests",
                 ops_sent[0], ops_sent[1], ops_sent[2], ops_sent[3]);
        $display("Checked %0d result words: %0d entries, %0d empty, %0d full, %0d misses",
                 words_checked, status_seen[1], status_seen[2], status_seen[3],
                 status_seen[4]);
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
